// File: design/sgs_pkg.sv
// sgs_pkg: shared types and constants for the servo gate sequencer
// no dependencies; used by every module of the block
package sgs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ANGLE_W    = 8;
  localparam int PULSE_W    = 12;
  localparam int DUTY_W     = 8;
  localparam int TICK_W     = 16;
  localparam int PROD_W     = PULSE_W + ANGLE_W;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [DUTY_W-1:0]  DUTY_BRAKE  = 8'd255;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd1472;

  // x / 180 is taken as (x >> 2) / 45, and q / 45 as (q * DIV45_RECIP) >> DIV45_SHIFT,
  // exact for q below 2^24 / 44
  localparam int                 DIV45_SHIFT = 24;
  localparam int                 QUOT_W      = PROD_W - 2;
  localparam logic [18:0]        DIV45_RECIP = 19'd372828;

  localparam logic [ANGLE_W-1:0] RST_CENTER   = 8'd90;
  localparam logic [ANGLE_W-1:0] RST_OFFSET   = 8'd60;
  localparam logic [TICK_W-1:0]  RST_HOLD     = 16'd2000;
  localparam logic [TICK_W-1:0]  RST_SETTLE   = 16'd1000;
  localparam logic [TICK_W-1:0]  RST_HOLDOFF  = 16'd1000;
  localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 12'd544;
  localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 12'd2400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER    = 3'd0,
    CFG_OFFSET    = 3'd1,
    CFG_HOLD      = 3'd2,
    CFG_SETTLE    = 3'd3,
    CFG_HOLDOFF   = 3'd4,
    CFG_PULSE_MIN = 3'd5,
    CFG_PULSE_MAX = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_MOVE_RIGHT = 3'd1,
    ACT_MOVE_LEFT  = 3'd2,
    ACT_MOVE       = 3'd3,
    ACT_DC_START   = 3'd4,
    ACT_DC_STOP    = 3'd5,
    ACT_SENSOR     = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_SETTLE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SEL_KEEP = 2'd0,
    SEL_ZERO = 2'd1,
    SEL_CALC = 2'd2
  } pulse_sel_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  center_angle;
    logic [ANGLE_W-1:0]  offset_angle;
    logic [TICK_W-1:0]   hold_ticks;
    logic [TICK_W-1:0]   settle_ticks;
    logic [TICK_W-1:0]   sensor_holdoff;
    logic [PULSE_W-1:0]  pulse_min_us;
    logic [PULSE_W-1:0]  pulse_max_us;
  } cfg_t;

  // result of one item's state update, carried down the pulse pipeline
  typedef struct packed {
    pulse_sel_t          sel;
    logic [ANGLE_W-1:0]  angle;
    phase_t              phase;
    logic [DUTY_W-1:0]   duty;
    logic                detected;
  } status_t;

endpackage

// File: design/sgs_ctrl.sv
// sgs_ctrl: sequence state, timers and dc duty, updated once per item
// depends on sgs_pkg
module sgs_ctrl #(
  parameter int TIMER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [2:0]           action,
  input  logic signed [9:0]    speed,
  input  sgs_pkg::cfg_t        cfg,
  output sgs_pkg::status_t     status
);

  localparam int CMP_W = (TIMER_BITS > sgs_pkg::TICK_W) ? TIMER_BITS : sgs_pkg::TICK_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  sgs_pkg::phase_t              seq_phase, seq_phase_next;
  logic [TIMER_BITS-1:0]        phase_timer, phase_timer_next;
  logic [TIMER_BITS-1:0]        since_detect, since_detect_next;
  logic [sgs_pkg::DUTY_W-1:0]   duty_reg, duty_reg_next;

  logic [TIMER_BITS-1:0]        pt_inc, sd_inc;
  logic [sgs_pkg::ANGLE_W:0]    sum_angle;
  logic [sgs_pkg::ANGLE_W-1:0]  diff_angle;
  logic [sgs_pkg::ANGLE_W-1:0]  up_angle, down_angle, mid_angle;
  logic                         idle;
  logic                         hold_done, settle_done, sense_ok;

  assign pt_inc = (phase_timer == TIMER_MAX) ? phase_timer : phase_timer + 1'b1;
  assign sd_inc = (since_detect == TIMER_MAX) ? since_detect : since_detect + 1'b1;
  assign idle   = (seq_phase == sgs_pkg::PH_IDLE);

  assign hold_done   = (seq_phase == sgs_pkg::PH_HOLD) &&
                       (CMP_W'(pt_inc) >= CMP_W'(cfg.hold_ticks));
  assign settle_done = (seq_phase == sgs_pkg::PH_SETTLE) &&
                       (CMP_W'(pt_inc) >= CMP_W'(cfg.settle_ticks));
  assign sense_ok    = idle && (CMP_W'(since_detect) > CMP_W'(cfg.sensor_holdoff));

  // angle candidates clamped to 0..180
  always_comb begin
    sum_angle  = {1'b0, cfg.center_angle} + {1'b0, cfg.offset_angle};
    diff_angle = (cfg.offset_angle >= cfg.center_angle) ? '0
                 : cfg.center_angle - cfg.offset_angle;
    up_angle   = (sum_angle > {1'b0, sgs_pkg::ANGLE_MAX}) ? sgs_pkg::ANGLE_MAX
                 : sum_angle[sgs_pkg::ANGLE_W-1:0];
    down_angle = (diff_angle > sgs_pkg::ANGLE_MAX) ? sgs_pkg::ANGLE_MAX : diff_angle;
    mid_angle  = (cfg.center_angle > sgs_pkg::ANGLE_MAX) ? sgs_pkg::ANGLE_MAX
                 : cfg.center_angle;
  end

  // next state
  always_comb begin
    seq_phase_next    = seq_phase;
    phase_timer_next  = phase_timer;
    since_detect_next = since_detect;
    duty_reg_next     = duty_reg;
    case (action)
      sgs_pkg::ACT_TICK: begin
        phase_timer_next  = pt_inc;
        since_detect_next = sd_inc;
        if (hold_done) begin
          seq_phase_next   = sgs_pkg::PH_SETTLE;
          phase_timer_next = '0;
        end else if (settle_done) begin
          seq_phase_next = sgs_pkg::PH_IDLE;
        end
      end
      sgs_pkg::ACT_MOVE_RIGHT, sgs_pkg::ACT_MOVE, sgs_pkg::ACT_MOVE_LEFT: begin
        if (idle) begin
          seq_phase_next   = sgs_pkg::PH_HOLD;
          phase_timer_next = '0;
        end
      end
      sgs_pkg::ACT_DC_START: begin
        if (speed[9]) begin
          duty_reg_next = sgs_pkg::DUTY_BRAKE;
        end else if (speed[8]) begin
          duty_reg_next = '0;
        end else begin
          duty_reg_next = ~speed[7:0];
        end
      end
      sgs_pkg::ACT_DC_STOP: begin
        duty_reg_next = sgs_pkg::DUTY_BRAKE;
      end
      sgs_pkg::ACT_SENSOR: begin
        if (sense_ok) begin
          since_detect_next = '0;
          seq_phase_next    = sgs_pkg::PH_HOLD;
          phase_timer_next  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // outputs
  always_comb begin
    status.sel      = sgs_pkg::SEL_KEEP;
    status.angle    = up_angle;
    status.detected = 1'b0;
    case (action)
      sgs_pkg::ACT_TICK: begin
        if (hold_done) begin
          status.sel   = sgs_pkg::SEL_CALC;
          status.angle = mid_angle;
        end else if (settle_done) begin
          status.sel = sgs_pkg::SEL_ZERO;
        end
      end
      sgs_pkg::ACT_MOVE_RIGHT, sgs_pkg::ACT_MOVE: begin
        if (idle) begin
          status.sel = sgs_pkg::SEL_CALC;
        end
      end
      sgs_pkg::ACT_MOVE_LEFT: begin
        if (idle) begin
          status.sel   = sgs_pkg::SEL_CALC;
          status.angle = down_angle;
        end
      end
      sgs_pkg::ACT_SENSOR: begin
        if (sense_ok) begin
          status.detected = 1'b1;
          status.sel      = sgs_pkg::SEL_CALC;
        end
      end
      default: begin
      end
    endcase
    status.phase = seq_phase_next;
    status.duty  = duty_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase    <= sgs_pkg::PH_IDLE;
      phase_timer  <= '0;
      since_detect <= TIMER_MAX;
      duty_reg     <= sgs_pkg::DUTY_BRAKE;
    end else if (fire) begin
      seq_phase    <= seq_phase_next;
      phase_timer  <= phase_timer_next;
      since_detect <= since_detect_next;
      duty_reg     <= duty_reg_next;
    end
  end

endmodule

// File: design/sgs_pulse.sv
// sgs_pulse: angle to pulse width pipeline (span multiply, divide by 180) and result register
// depends on sgs_pkg
module sgs_pulse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sgs_pkg::status_t              status,
  input  sgs_pkg::cfg_t                 cfg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sgs_pkg::PULSE_W-1:0]   servo_pulse_us,
  output logic [sgs_pkg::DUTY_W-1:0]    dc_duty,
  output logic                          detected,
  output logic [1:0]                    phase
);

  localparam int MUL_W = sgs_pkg::QUOT_W + 19;

  logic                          b_valid, c_valid;
  logic                          b_en, c_en, d_en;
  sgs_pkg::status_t              b_status, c_status;
  logic [sgs_pkg::PROD_W-1:0]    b_prod;
  logic [sgs_pkg::PULSE_W-1:0]   c_quot;
  logic [sgs_pkg::PULSE_W-1:0]   span;
  logic [MUL_W-1:0]              recip_prod;
  logic [sgs_pkg::PULSE_W-1:0]   pulse_next;

  assign d_en     = !out_valid || !out_stall;
  assign c_en     = !c_valid || d_en;
  assign b_en     = !b_valid || c_en;
  assign in_stall = !b_en;

  assign span = (cfg.pulse_max_us >= cfg.pulse_min_us)
                ? cfg.pulse_max_us - cfg.pulse_min_us : '0;

  assign recip_prod = MUL_W'(b_prod[sgs_pkg::PROD_W-1:2]) * MUL_W'(sgs_pkg::DIV45_RECIP);

  always_comb begin
    case (c_status.sel)
      sgs_pkg::SEL_CALC: pulse_next = cfg.pulse_min_us + c_quot;
      sgs_pkg::SEL_ZERO: pulse_next = '0;
      default:           pulse_next = servo_pulse_us;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
      out_valid      <= 1'b0;
      servo_pulse_us <= sgs_pkg::PULSE_RESET;
    end else begin
      if (b_en) begin
        b_valid <= in_valid;
      end
      if (c_en) begin
        c_valid <= b_valid;
      end
      if (d_en) begin
        out_valid <= c_valid;
        if (c_valid) begin
          servo_pulse_us <= pulse_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_status <= status;
      b_prod   <= sgs_pkg::PROD_W'(span) * sgs_pkg::PROD_W'(status.angle);
    end
    if (c_en) begin
      c_status <= b_status;
      c_quot   <= recip_prod[sgs_pkg::DIV45_SHIFT +: sgs_pkg::PULSE_W];
    end
    if (d_en && c_valid) begin
      dc_duty  <= c_status.duty;
      detected <= c_status.detected;
      phase    <= c_status.phase;
    end
  end

endmodule

// File: design/servo_gate_sequencer_unit.sv
// servo_gate_sequencer_unit: top level, configuration registers and input register
// depends on sgs_pkg, sgs_ctrl and sgs_pulse
//
// One result per transfer in, one transfer per cycle sustained while out_stall is low. A
// result passes the input register, where the sequence state updates, then the span
// multiply and the divide-by-180 reciprocal multiply each take a registered stage before
// the result register. Configuration registers are read by every stage, so writes also
// reach items in flight; configuration writes are meant for an idle block.
module servo_gate_sequencer_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           action,
  input  logic signed [9:0]                    speed,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [sgs_pkg::PULSE_W-1:0]          servo_pulse_us,
  output logic [sgs_pkg::DUTY_W-1:0]           dc_duty,
  output logic                                 detected,
  output logic [1:0]                           phase
);

  sgs_pkg::cfg_t     cfg;
  sgs_pkg::status_t  status;
  logic              a_valid;
  logic [2:0]        a_action;
  logic signed [9:0] a_speed;
  logic              a_stall;
  logic              a_fire;

  assign in_stall = a_valid && a_stall;
  assign a_fire   = a_valid && !a_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_angle   <= sgs_pkg::RST_CENTER;
      cfg.offset_angle   <= sgs_pkg::RST_OFFSET;
      cfg.hold_ticks     <= sgs_pkg::RST_HOLD;
      cfg.settle_ticks   <= sgs_pkg::RST_SETTLE;
      cfg.sensor_holdoff <= sgs_pkg::RST_HOLDOFF;
      cfg.pulse_min_us   <= sgs_pkg::RST_PULSE_MIN;
      cfg.pulse_max_us   <= sgs_pkg::RST_PULSE_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        sgs_pkg::CFG_CENTER:    cfg.center_angle   <= cfg_data[sgs_pkg::ANGLE_W-1:0];
        sgs_pkg::CFG_OFFSET:    cfg.offset_angle   <= cfg_data[sgs_pkg::ANGLE_W-1:0];
        sgs_pkg::CFG_HOLD:      cfg.hold_ticks     <= cfg_data;
        sgs_pkg::CFG_SETTLE:    cfg.settle_ticks   <= cfg_data;
        sgs_pkg::CFG_HOLDOFF:   cfg.sensor_holdoff <= cfg_data;
        sgs_pkg::CFG_PULSE_MIN: cfg.pulse_min_us   <= cfg_data[sgs_pkg::PULSE_W-1:0];
        sgs_pkg::CFG_PULSE_MAX: cfg.pulse_max_us   <= cfg_data[sgs_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_action <= action;
      a_speed  <= speed;
    end
  end

  sgs_ctrl #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .fire   (a_fire),
    .action (a_action),
    .speed  (a_speed),
    .cfg    (cfg),
    .status (status)
  );

  sgs_pulse u_pulse (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (a_valid),
    .in_stall       (a_stall),
    .status         (status),
    .cfg            (cfg),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .servo_pulse_us (servo_pulse_us),
    .dc_duty        (dc_duty),
    .detected       (detected),
    .phase          (phase)
  );

endmodule

// File: design/sgs_checker.sv
// sgs_checker: port-level assertions for servo_gate_sequencer_unit
// depends on sgs_pkg; bound to the top level at the end of this file
module sgs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sgs_pkg::PULSE_W-1:0]   servo_pulse_us,
  input logic [sgs_pkg::DUTY_W-1:0]    dc_duty,
  input logic                          detected,
  input logic [1:0]                    phase
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // input side only backs up behind a stalled result
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no stalled result");

  // a detection always starts the holding phase
  a_detect_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && detected) |-> (phase == 2'(sgs_pkg::PH_HOLD)))
    else $error("detection without holding phase");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(servo_pulse_us) &&
                                  $stable(dc_duty) && $stable(detected) && $stable(phase)))
    else $error("stalled result changed");

endmodule

bind servo_gate_sequencer_unit sgs_checker u_sgs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .servo_pulse_us (servo_pulse_us),
  .dc_duty        (dc_duty),
  .detected       (detected),
  .phase          (phase)
);

// File: tb/sgs_gate_checker.sv
`timescale 1ns / 100ps
// sgs_gate_checker: watches every transfer of the servo gate sequencer, predicts each
// result from its own copy of the sequence state and registers, and compares the outputs
// depends on sgs_pkg for the action, phase and register codes
module sgs_gate_checker #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [2:0]                     action,
  input  logic signed [9:0]              speed,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [sgs_pkg::PULSE_W-1:0]    servo_pulse_us,
  input  logic [sgs_pkg::DUTY_W-1:0]     dc_duty,
  input  logic                           detected,
  input  logic [1:0]                     phase,
  output logic [31:0]                    mismatch_total,
  output logic [31:0]                    queued_results
);

  typedef struct packed {
    logic [sgs_pkg::PULSE_W-1:0] pulse;
    logic [sgs_pkg::DUTY_W-1:0]  duty;
    logic                        det;
    logic [1:0]                  ph;
  } gate_out_t;

  localparam logic [TIMER_BITS-1:0] TIMER_SAT = '1;

  logic [sgs_pkg::ANGLE_W-1:0] center_q;
  logic [sgs_pkg::ANGLE_W-1:0] offset_q;
  logic [sgs_pkg::TICK_W-1:0]  hold_q;
  logic [sgs_pkg::TICK_W-1:0]  settle_q;
  logic [sgs_pkg::TICK_W-1:0]  holdoff_q;
  logic [sgs_pkg::PULSE_W-1:0] pmin_q;
  logic [sgs_pkg::PULSE_W-1:0] pmax_q;
  sgs_pkg::phase_t             phase_q;
  logic [TIMER_BITS-1:0]       timer_q;
  logic [TIMER_BITS-1:0]       since_q;
  logic [sgs_pkg::PULSE_W-1:0] pulse_q;
  logic [sgs_pkg::DUTY_W-1:0]  duty_q;

  gate_out_t gate_outputs_due[$];
  int        mismatch_count = 0;
  int        due_count = 0;

  assign mismatch_total = mismatch_count;
  assign queued_results = due_count;

  task automatic report_mismatch(input string msg);
    $display("%0t sgs_gate_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic logic [sgs_pkg::PULSE_W-1:0] pulse_for(input int angle);
    int deg;
    int span;
    int width_us;
    deg      = (angle < 0) ? 0 : (angle > 180) ? 180 : angle;
    span     = (pmax_q >= pmin_q) ? int'(pmax_q) - int'(pmin_q) : 0;
    width_us = int'(pmin_q) + span * deg / 180;
    return width_us[sgs_pkg::PULSE_W-1:0];
  endfunction

  function automatic void start_swing(input int angle);
    pulse_q = pulse_for(angle);
    phase_q = sgs_pkg::PH_HOLD;
    timer_q = '0;
  endfunction

  function automatic gate_out_t step_gate(input logic [2:0] act, input logic signed [9:0] spd);
    gate_out_t res;
    int        rate;
    res.det = 1'b0;
    case (act)
      sgs_pkg::ACT_TICK: begin
        if (timer_q != TIMER_SAT) timer_q = timer_q + 1'b1;
        if (since_q != TIMER_SAT) since_q = since_q + 1'b1;
        if (phase_q == sgs_pkg::PH_HOLD && timer_q >= hold_q) begin
          pulse_q = pulse_for(int'(center_q));
          phase_q = sgs_pkg::PH_SETTLE;
          timer_q = '0;
        end else if (phase_q == sgs_pkg::PH_SETTLE && timer_q >= settle_q) begin
          pulse_q = '0;
          phase_q = sgs_pkg::PH_IDLE;
        end
      end
      sgs_pkg::ACT_MOVE_RIGHT, sgs_pkg::ACT_MOVE: begin
        if (phase_q == sgs_pkg::PH_IDLE) start_swing(int'(center_q) + int'(offset_q));
      end
      sgs_pkg::ACT_MOVE_LEFT: begin
        if (phase_q == sgs_pkg::PH_IDLE) start_swing(int'(center_q) - int'(offset_q));
      end
      sgs_pkg::ACT_DC_START: begin
        rate = spd;
        if (rate < 0) rate = 0;
        if (rate > 255) rate = 255;
        duty_q = sgs_pkg::DUTY_BRAKE - rate[sgs_pkg::DUTY_W-1:0];
      end
      sgs_pkg::ACT_DC_STOP: begin
        duty_q = sgs_pkg::DUTY_BRAKE;
      end
      sgs_pkg::ACT_SENSOR: begin
        if (phase_q == sgs_pkg::PH_IDLE && since_q > holdoff_q) begin
          res.det = 1'b1;
          since_q = '0;
          start_swing(int'(center_q) + int'(offset_q));
        end
      end
      default: begin
      end
    endcase
    res.pulse = pulse_q;
    res.duty  = duty_q;
    res.ph    = phase_q;
    return res;
  endfunction

  // sample at the falling edge: everything here changes only at the rising edge
  always @(negedge clk) begin
    gate_out_t due;
    if (rst) begin
      center_q  = sgs_pkg::RST_CENTER;
      offset_q  = sgs_pkg::RST_OFFSET;
      hold_q    = sgs_pkg::RST_HOLD;
      settle_q  = sgs_pkg::RST_SETTLE;
      holdoff_q = sgs_pkg::RST_HOLDOFF;
      pmin_q    = sgs_pkg::RST_PULSE_MIN;
      pmax_q    = sgs_pkg::RST_PULSE_MAX;
      phase_q   = sgs_pkg::PH_IDLE;
      timer_q   = '0;
      since_q   = TIMER_SAT;
      pulse_q   = pulse_for(int'(sgs_pkg::RST_CENTER));
      duty_q    = sgs_pkg::DUTY_BRAKE;
      gate_outputs_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgs_pkg::CFG_CENTER:    center_q  = cfg_data[sgs_pkg::ANGLE_W-1:0];
          sgs_pkg::CFG_OFFSET:    offset_q  = cfg_data[sgs_pkg::ANGLE_W-1:0];
          sgs_pkg::CFG_HOLD:      hold_q    = cfg_data[sgs_pkg::TICK_W-1:0];
          sgs_pkg::CFG_SETTLE:    settle_q  = cfg_data[sgs_pkg::TICK_W-1:0];
          sgs_pkg::CFG_HOLDOFF:   holdoff_q = cfg_data[sgs_pkg::TICK_W-1:0];
          sgs_pkg::CFG_PULSE_MIN: pmin_q    = cfg_data[sgs_pkg::PULSE_W-1:0];
          sgs_pkg::CFG_PULSE_MAX: pmax_q    = cfg_data[sgs_pkg::PULSE_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (gate_outputs_due.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing pending, pulse %0d",
                                    servo_pulse_us));
        end else begin
          due = gate_outputs_due.pop_front();
          if (servo_pulse_us !== due.pulse)
            report_mismatch($sformatf("servo_pulse_us got %0d expected %0d",
                                      servo_pulse_us, due.pulse));
          if (dc_duty !== due.duty)
            report_mismatch($sformatf("dc_duty got %0d expected %0d", dc_duty, due.duty));
          if (detected !== due.det)
            report_mismatch($sformatf("detected got %0d expected %0d", detected, due.det));
          if (phase !== due.ph)
            report_mismatch($sformatf("phase got %0d expected %0d", phase, due.ph));
        end
      end
      if (in_valid && !in_stall) gate_outputs_due.push_back(step_gate(action, speed));
    end
    due_count = gate_outputs_due.size();
  end

endmodule

// File: tb/tb_servo_gate_sequencer_unit.sv
`timescale 1ns / 100ps
// tb_servo_gate_sequencer_unit: drives commands, ticks and register settings into the
// servo gate sequencer with random idling on both sides and gives the verdict
// depends on sgs_pkg, servo_gate_sequencer_unit and sgs_gate_checker
module tb_servo_gate_sequencer_unit;

  localparam int TIMER_BITS      = 16;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int LONG_HOLD       = 400;
  localparam int TAIL_CYCLES     = 20;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 235;

  localparam logic [2:0]                    ACT_UNUSED = 3'd7;
  localparam logic [sgs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [sgs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sgs_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                           in_valid;
  logic                           in_stall;
  logic [2:0]                     action;
  logic signed [9:0]              speed;
  logic                           out_valid;
  logic                           out_stall;
  logic [sgs_pkg::PULSE_W-1:0]    servo_pulse_us;
  logic [sgs_pkg::DUTY_W-1:0]     dc_duty;
  logic                           detected;
  logic [1:0]                     phase;
  logic [31:0]                    mismatch_total;
  logic [31:0]                    queued_results;

  logic idle_on = 1'b1;
  logic long_stall_req = 1'b0;
  int   quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  servo_gate_sequencer_unit #(
    .TIMER_BITS(TIMER_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .speed(speed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .servo_pulse_us(servo_pulse_us),
    .dc_duty(dc_duty),
    .detected(detected),
    .phase(phase)
  );

  sgs_gate_checker #(
    .TIMER_BITS(TIMER_BITS)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .speed(speed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .servo_pulse_us(servo_pulse_us),
    .dc_duty(dc_duty),
    .detected(detected),
    .phase(phase),
    .mismatch_total(mismatch_total),
    .queued_results(queued_results)
  );

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_servo_gate_sequencer_unit: done, errors");
      $finish;
    end
  end

  // result side: one long hold-off on request, otherwise short random stall bursts
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [9:0] spd);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    speed    <= spd;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (queued_results != 0);
  endtask

  task automatic write_reg(input logic [sgs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sgs_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // unused upper data bits carry random junk
  task automatic set_config(input int center, offset, hold, settle, holdoff, pmin, pmax);
    write_reg(sgs_pkg::CFG_CENTER, {8'($urandom), 8'(center)});
    write_reg(sgs_pkg::CFG_OFFSET, {8'($urandom), 8'(offset)});
    write_reg(sgs_pkg::CFG_HOLD, 16'(hold));
    write_reg(sgs_pkg::CFG_SETTLE, 16'(settle));
    write_reg(sgs_pkg::CFG_HOLDOFF, 16'(holdoff));
    write_reg(sgs_pkg::CFG_PULSE_MIN, {4'($urandom), 12'(pmin)});
    write_reg(sgs_pkg::CFG_PULSE_MAX, {4'($urandom), 12'(pmax)});
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // ticks dominate so that sequences run through hold and settle
  function automatic logic [2:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return sgs_pkg::ACT_TICK;
    if (r < 58) return sgs_pkg::ACT_MOVE_RIGHT;
    if (r < 66) return sgs_pkg::ACT_MOVE_LEFT;
    if (r < 72) return sgs_pkg::ACT_MOVE;
    if (r < 80) return sgs_pkg::ACT_SENSOR;
    if (r < 88) return sgs_pkg::ACT_DC_START;
    if (r < 96) return sgs_pkg::ACT_DC_STOP;
    return ACT_UNUSED;
  endfunction

  initial begin
    logic [2:0] act;
    logic [9:0] spd;
    int         c, o, hd, st, hf, lo, hi;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= sgs_pkg::CFG_CENTER;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    action    <= sgs_pkg::ACT_TICK;
    speed     <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset registers: center pulse, brake, holdoff expired
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_DC_START, 10'h1ff);
    send_item(sgs_pkg::ACT_DC_START, 10'h200);
    send_item(sgs_pkg::ACT_DC_START, 10'd255);
    send_item(sgs_pkg::ACT_DC_START, 10'd0);
    send_item(sgs_pkg::ACT_DC_START, 10'd100);
    send_item(sgs_pkg::ACT_DC_STOP, 10'h3ff);
    send_item(ACT_UNUSED, 10'h155);
    send_item(sgs_pkg::ACT_SENSOR, 10'h2aa);
    send_item(sgs_pkg::ACT_MOVE_LEFT, 10'd0);
    send_item(sgs_pkg::ACT_SENSOR, 10'd0);

    // zero hold and settle, angle above range, max pulse below min
    drain_results();
    set_config(180, 180, 0, 0, 0, 4095, 0);
    send_item(sgs_pkg::ACT_MOVE, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_MOVE_LEFT, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_SENSOR, 10'd0);
    send_item(sgs_pkg::ACT_SENSOR, 10'd0);

    // angle below zero, full pulse span
    drain_results();
    set_config(0, 180, 1, 1, 0, 0, 4095);
    send_item(sgs_pkg::ACT_MOVE_LEFT, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_TICK, 10'd0);
    send_item(sgs_pkg::ACT_MOVE_RIGHT, 10'd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c  = (ph == 1) ? 0 : (ph == 2) ? 180 : $urandom_range(0, 180);
      o  = (ph == 1) ? 180 : (ph == 2) ? 0 : $urandom_range(0, 180);
      hd = (ph == 3) ? 65535 : $urandom_range(0, 12);
      st = (ph == 4) ? 65535 : $urandom_range(0, 12);
      hf = (ph == 5) ? 65535 : $urandom_range(0, 30);
      lo = (ph == 6) ? $urandom_range(2048, 4095) : (ph == 2) ? 0 : $urandom_range(0, 1500);
      hi = (ph == 6) ? $urandom_range(0, 2047) : (ph == 2) ? 4095 : $urandom_range(1000, 4095);
      drain_results();
      set_config(c, o, hd, st, hf, lo, hi);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
        if (ph == 2 && n == 60) long_stall_req = 1'b1;
        act = pick_action();
        if (act == sgs_pkg::ACT_DC_START && $urandom_range(0, 1) == 1) begin
          spd = 10'($urandom_range(0, 255));
        end else begin
          spd = 10'($urandom);
        end
        send_item(act, spd);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("tb_servo_gate_sequencer_unit: done, clean");
    end else begin
      $display("tb_servo_gate_sequencer_unit: done, errors");
    end
    $finish;
  end

endmodule
